[rtl/core/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by every module of the block.
`default_nettype none
package mexp_pkg;

  localparam int unsigned MSG_W   = 8;    // message value width
  localparam int unsigned VAL_W   = 31;   // exponent, modulus and residue width
  localparam int unsigned BIT_W   = 5;    // index over VAL_W bits
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0] EXP_RESET = VAL_W'(5);
  localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(221);
  localparam logic [BIT_W-1:0] TOP_BIT   = BIT_W'(VAL_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

  // Operand selection for the modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE,  // 1 * message : reduces the base
    OP_SQUARE,  // acc * acc
    OP_MULT     // acc * base
  } op_e;

  // Source of the result register
  typedef enum logic [1:0] {
    FIN_ZERO,   // modulus below two
    FIN_ONE,    // zero exponent
    FIN_MUL     // last multiplier product
  } fin_e;

  typedef struct packed {
    logic             load;       // latch message, acc <= 1
    logic             mul_start;
    op_e              op;
    logic             wr_base;
    logic             wr_acc;
    logic             finish;
    fin_e             fin_sel;
    logic [BIT_W-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic exp_zero;
    logic mod_small;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/modular_exponentiation.sv]
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_ctrl, mexp_datapath (and mexp_mulmod below it).
`default_nettype none
// Computes cipher_value = message_value ^ exponent mod modulus by left-to-right
// square-and-multiply. A request is taken when start is high while busy is
// low. The base is first reduced modulo the modulus, then every one of the 31
// exponent bits costs a square and each set bit also a multiply. All products
// go through one bit-serial modular multiplier: a launch, one shift-add-reduce
// step per operand bit, then a result. busy stays high until the last product
// of a request is written; done_o strobes, and cipher_value_o takes the result,
// in the same cycle that busy drops. With a zero exponent
// or a modulus below two the answer (1, or 0 for the small modulus) strobes in
// the cycle right after the request. done_o is high for exactly one cycle and
// the receiver cannot stall it; cipher_value_o holds until the next result, and
// a new request may be issued in the strobe cycle. Configuration (index 0:
// exponent, index 1: modulus, reset 5 and 221) is written through cfg_we_i and
// must only change while busy is low and no strobe is pending.
module modular_exponentiation (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [mexp_pkg::VAL_W-1:0]      cfg_wdata_i,
  input  wire                            start,
  output logic                           busy,
  input  wire [mexp_pkg::MSG_W-1:0]      message_value_i,
  output logic                           done_o,
  output logic [mexp_pkg::VAL_W-1:0]     cipher_value_o
);
  import mexp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: idle, base reduction, then square / multiply per exponent bit
  mexp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // registers, operand muxing, serial multiplier and result register
  mexp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .message_value_i (message_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cipher_value_o  (cipher_value_o)
  );

endmodule
`default_nettype wire

[rtl/core/mexp_mulmod.sv]
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg. Requires a < m.
`default_nettype none
module mexp_mulmod (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [mexp_pkg::VAL_W-1:0]    a_i,
  input  wire [mexp_pkg::VAL_W-1:0]    b_i,
  input  wire [mexp_pkg::VAL_W-1:0]    m_i,
  output logic                         done_o,
  output logic [mexp_pkg::VAL_W-1:0]   r_o
);
  import mexp_pkg::*;

  logic [VAL_W-1:0] a_q, b_q, m_q, r_q, r_d;
  logic [BIT_W-1:0] cnt_q;
  logic             running_q, done_q;
  logic [VAL_W+1:0] t, m1, m2;

  // r <= (2r + bit*a) mod m; the sum stays below 3m
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[VAL_W-1] ? a_q : '0)};
    m1 = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    if (t >= m2) begin
      r_d = VAL_W'(t - m2);
    end else if (t >= m1) begin
      r_d = VAL_W'(t - m1);
    end else begin
      r_d = VAL_W'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= TOP_BIT;
      end else if (running_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          running_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (running_q) begin
      r_q <= r_d;
      b_q <= {b_q[VAL_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !running_q)
    else $error("multiplier restarted while running");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q && cnt_q == '0 && !start_i) |=> done_q)
    else $error("multiplier missed its done pulse");
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && m_q >= VAL_W'(2)) |-> r_q < m_q)
    else $error("multiplier result not reduced");

endmodule
`default_nettype wire

[rtl/core/mexp_datapath.sv]
// Datapath: configuration registers, base and accumulator, result register.
// Depends on mexp_pkg and mexp_mulmod.
`default_nettype none
module mexp_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [mexp_pkg::VAL_W-1:0]      cfg_wdata_i,
  input  wire [mexp_pkg::MSG_W-1:0]      message_value_i,
  input  wire mexp_pkg::cmd_t            cmd_i,
  output mexp_pkg::stat_t                stat_o,
  output logic [mexp_pkg::VAL_W-1:0]     cipher_value_o
);
  import mexp_pkg::*;

  logic [VAL_W-1:0] exponent_q, modulus_q;
  logic [VAL_W-1:0] base_q, acc_q, cipher_q;
  logic [VAL_W-1:0] mm_a, mm_b, mm_r;
  logic             mm_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= EXP_RESET;
      modulus_q  <= MOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPONENT: exponent_q <= cfg_wdata_i;
        CFG_MODULUS:  modulus_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_REDUCE: begin
        mm_a = VAL_W'(1);
        mm_b = base_q;
      end
      OP_SQUARE: begin
        mm_a = acc_q;
        mm_b = acc_q;
      end
      OP_MULT: begin
        mm_a = acc_q;
        mm_b = base_q;
      end
      default: begin
        mm_a = acc_q;
        mm_b = base_q;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (modulus_q),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= {{(VAL_W-MSG_W){1'b0}}, message_value_i};
      acc_q  <= VAL_W'(1);
    end else begin
      if (cmd_i.wr_base) base_q <= mm_r;
      if (cmd_i.wr_acc)  acc_q  <= mm_r;
    end
    if (cmd_i.finish) begin
      case (cmd_i.fin_sel)
        FIN_ZERO: cipher_q <= '0;
        FIN_ONE:  cipher_q <= VAL_W'(1);
        FIN_MUL:  cipher_q <= mm_r;
        default:  cipher_q <= mm_r;
      endcase
    end
  end

  assign stat_o.mul_done  = mm_done;
  assign stat_o.exp_bit   = exponent_q[cmd_i.bit_idx];
  assign stat_o.exp_zero  = (exponent_q == '0);
  assign stat_o.mod_small = (modulus_q < VAL_W'(2));
  assign cipher_value_o   = cipher_q;

endmodule
`default_nettype wire

[rtl/core/mexp_ctrl.sv]
// Controller: sequences base reduction and the square-and-multiply scan.
// Depends on mexp_pkg; drives mexp_datapath through cmd_t.
`default_nettype none
module mexp_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire mexp_pkg::stat_t stat_i,
  output mexp_pkg::cmd_t       cmd_o,
  output logic                 done_o
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT
  } state_e;

  state_e           state_q;
  logic [BIT_W-1:0] idx_q;
  logic             done_q;
  logic             accept, trivial, last_bit;

  assign accept   = start && (state_q == ST_IDLE);
  assign trivial  = stat_i.mod_small || stat_i.exp_zero;
  assign last_bit = (idx_q == '0);

  always_comb begin
    cmd_o         = '0;
    cmd_o.bit_idx = idx_q;
    cmd_o.op      = OP_REDUCE;
    cmd_o.fin_sel = FIN_MUL;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load    = 1'b1;
          cmd_o.finish  = trivial;
          cmd_o.fin_sel = stat_i.mod_small ? FIN_ZERO : FIN_ONE;
        end
      end
      ST_RED_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op        = OP_REDUCE;
      end
      ST_RED_WAIT: begin
        cmd_o.op      = OP_REDUCE;
        cmd_o.wr_base = stat_i.mul_done;
      end
      ST_SQ_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op        = OP_SQUARE;
      end
      ST_SQ_WAIT: begin
        cmd_o.op     = OP_SQUARE;
        cmd_o.wr_acc = stat_i.mul_done;
        cmd_o.finish = stat_i.mul_done && !stat_i.exp_bit && last_bit;
      end
      ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op        = OP_MULT;
      end
      ST_MUL_WAIT: begin
        cmd_o.op     = OP_MULT;
        cmd_o.wr_acc = stat_i.mul_done;
        cmd_o.finish = stat_i.mul_done && last_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_o.finish;
      case (state_q)
        ST_IDLE: begin
          if (accept && !trivial) begin
            state_q <= ST_RED_GO;
            idx_q   <= TOP_BIT;
          end
        end
        ST_RED_GO:   state_q <= ST_RED_WAIT;
        ST_RED_WAIT: if (stat_i.mul_done) state_q <= ST_SQ_GO;
        ST_SQ_GO:    state_q <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (stat_i.mul_done) begin
            if (stat_i.exp_bit) begin
              state_q <= ST_MUL_GO;
            end else if (last_bit) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= ST_SQ_GO;
            end
          end
        end
        ST_MUL_GO:   state_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (stat_i.mul_done) begin
            if (last_bit) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= ST_SQ_GO;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !trivial) |=> (busy && !done_q))
    else $error("accepted request did not start");
  a_trivial_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && trivial) |=> (done_q && !busy))
    else $error("trivial request not answered at once");

endmodule
`default_nettype wire
